// ----- hw/rtl/tgr_pkg.sv -----
package tgr_pkg;

    localparam int unsigned CODE_W       = 8;
    localparam int unsigned ROW_W        = 4;
    localparam int unsigned PIX_W        = 16;
    localparam int unsigned NARROW_W     = 8;
    localparam int unsigned ATTR_W       = 4;

    localparam logic [6:0] CODE_LOW  = 7'h21;
    localparam logic [6:0] CODE_HIGH = 7'h7e;

    localparam logic [ROW_W-1:0] UNDERLINE_ROW = 4'd14;

    // attribute bit positions
    localparam int unsigned ATTR_INVERSE   = 0;
    localparam int unsigned ATTR_UNDERLINE = 1;
    localparam int unsigned ATTR_HEAVY     = 2;

    typedef struct packed {
        logic [CODE_W-1:0] lead_byte;
        logic [CODE_W-1:0] char_byte;
        logic [ROW_W-1:0]  glyph_row;
        logic [PIX_W-1:0]  font_bits;
        logic [ATTR_W-1:0] attributes;
    } glyph_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixels;
        logic             is_wide;
    } glyph_res_t;

endpackage

// ----- hw/rtl/tgr_row_if.sv -----
interface tgr_row_if;
    import tgr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] lead_byte;
    logic [CODE_W-1:0] char_byte;
    logic [ROW_W-1:0]  glyph_row;
    logic [PIX_W-1:0]  font_bits;
    logic [ATTR_W-1:0] attributes;

    modport source (
        output valid, lead_byte, char_byte, glyph_row, font_bits, attributes,
        input  ready
    );

    modport sink (
        input  valid, lead_byte, char_byte, glyph_row, font_bits, attributes,
        output ready
    );
endinterface

// ----- hw/rtl/tgr_pix_if.sv -----
interface tgr_pix_if;
    import tgr_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixels;
    logic             is_wide;

    modport source (
        output valid, pixels, is_wide,
        input  ready
    );

    modport sink (
        input  valid, pixels, is_wide,
        output ready
    );
endinterface

// ----- hw/rtl/tgr_render.sv -----
module tgr_render (
    input  tgr_pkg::glyph_req_t req,
    output tgr_pkg::glyph_res_t res
);
    import tgr_pkg::*;

    logic             wide;
    logic [6:0]       hi;
    logic [6:0]       lo;
    logic [PIX_W-1:0] mask;
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] bold;
    logic [PIX_W-1:0] beside;
    logic [PIX_W-1:0] uline;
    logic [PIX_W-1:0] final_row;

    always_comb
    begin
        hi   = req.lead_byte[6:0];
        lo   = req.char_byte[6:0];
        wide = (hi >= CODE_LOW) && (hi <= CODE_HIGH) && (lo >= CODE_LOW) && (lo <= CODE_HIGH);
        mask = wide ? {PIX_W{1'b1}} : {{(PIX_W-NARROW_W){1'b0}}, {NARROW_W{1'b1}}};
        base = req.font_bits & mask;

        bold = req.attributes[ATTR_HEAVY] ? ((base | (base >> 1)) & mask) : base;

        // gap of one pixel on either side of every stroke
        beside = ((bold << 1) | (bold >> 1)) & ~bold;
        uline  = (req.attributes[ATTR_UNDERLINE] && (req.glyph_row == UNDERLINE_ROW))
               ? (~beside & mask) : bold;

        final_row = req.attributes[ATTR_INVERSE] ? (~uline & mask) : uline;

        res.pixels  = final_row;
        res.is_wide = wide;
    end
endmodule

// ----- hw/rtl/text_glyph_row_attribute_render_unit.sv -----
// Glyph row renderer: takes one raster row per transaction (codes, row index,
// font row data, attributes) and returns the row's pixels, msb leftmost, plus
// a wide flag. Throughput is one row per clock while the result side accepts;
// each row passes through the input register, the render logic and the
// result register in turn. Ready depends combinationally on the result side's
// ready, so a full pipe keeps streaming under continuous downstream acceptance.
module text_glyph_row_attribute_render_unit (
    input  logic             clk,
    input  logic             rst_n,
    tgr_row_if.sink          row,
    tgr_pix_if.source        result
);
    import tgr_pkg::*;

    logic       in_valid_reg;
    glyph_req_t in_data_reg;
    logic       out_valid_reg;
    glyph_res_t out_data_reg;
    glyph_res_t render_res;
    logic       out_advance;
    logic       in_advance;

    tgr_render u_render (
        .req (in_data_reg),
        .res (render_res)
    );

    assign out_advance = !out_valid_reg || result.ready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign row.ready   = in_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_advance)
            begin
                in_valid_reg <= row.valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && row.valid)
        begin
            in_data_reg.lead_byte  <= row.lead_byte;
            in_data_reg.char_byte  <= row.char_byte;
            in_data_reg.glyph_row  <= row.glyph_row;
            in_data_reg.font_bits  <= row.font_bits;
            in_data_reg.attributes <= row.attributes;
        end
        if (out_advance && in_valid_reg)
        begin
            out_data_reg <= render_res;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.pixels  = out_data_reg.pixels;
    assign result.is_wide = out_data_reg.is_wide;

    a_accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        (row.valid && row.ready) |=> in_valid_reg)
        else $error("accepted row not held in input register");

    a_input_moves_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_advance) |=> out_valid_reg)
        else $error("input item lost on the way to the result register");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !row.ready |-> (in_valid_reg && out_valid_reg && !result.ready))
        else $error("input stalled with room in the pipe");

    a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.is_wide) |-> (out_data_reg.pixels[15:8] == 8'h00))
        else $error("narrow glyph has upper pixels set");
endmodule
